/* src/b2da_pkg.sv */
// ----------------------------------------------------------------------------
// b2da_pkg
// Shared types and constants for the binary to decimal ASCII unit.
// ----------------------------------------------------------------------------
package b2da_pkg;

  // Width of the value field on the request port.
  localparam int VALUE_W = 32;

  // Width of one ASCII digit on the result port.
  localparam int CHAR_W = 6;

  // ASCII '0', truncated to the result width.
  localparam logic [CHAR_W-1:0] ASCII_ZERO = 6'h30;

  // Width of one packed BCD digit.
  localparam int BCD_DIGIT_W = 4;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONVERT,
    ST_SCAN
  } b2da_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic shift;
    logic scan;
  } b2da_cmd_t;

  // Status from the datapath back to the controller.
  typedef struct packed {
    logic shift_done;
    logic scan_last;
  } b2da_sts_t;

endpackage

/* src/b2da_ctrl.sv */
// ----------------------------------------------------------------------------
// b2da_ctrl
// Controller that sequences loading, double-dabble shifting and digit scan.
// ----------------------------------------------------------------------------
module b2da_ctrl import b2da_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  input  b2da_sts_t sts,
  output b2da_cmd_t cmd,
  output logic      busy
);

  b2da_state_t state_r;
  b2da_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          state_nxt = ST_CONVERT;
        end
      end
      ST_CONVERT: begin
        if (sts.shift_done) begin
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (sts.scan_last) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    case (state_r)
      ST_IDLE: begin
        busy     = 1'b0;
        cmd.load = start;
      end
      ST_CONVERT: begin
        cmd.shift = 1'b1;
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
      end
      default: begin
        busy = 1'b0;
      end
    endcase
  end

endmodule

/* src/b2da_datapath.sv */
// ----------------------------------------------------------------------------
// b2da_datapath
// Double-dabble shift register, digit counters and registered result port.
// ----------------------------------------------------------------------------
module b2da_datapath import b2da_pkg::*; #(
  parameter int EFF_BITS   = 32,
  parameter int NUM_DIGITS = 10
) (
  input  logic               clk,
  input  logic               rst_n,
  input  b2da_cmd_t          cmd,
  input  logic [VALUE_W-1:0] in_value,
  output b2da_sts_t          sts,
  output logic               out_valid,
  output logic [CHAR_W-1:0]  out_digit_char,
  output logic               out_last_digit
);

  localparam int BCD_W     = NUM_DIGITS * BCD_DIGIT_W;
  localparam int BIT_CNT_W = $clog2(EFF_BITS);
  localparam int DIG_CNT_W = $clog2(NUM_DIGITS + 1);
  localparam logic [BIT_CNT_W-1:0] LAST_SHIFT = BIT_CNT_W'(EFF_BITS - 2);
  localparam logic [DIG_CNT_W-1:0] DIG_LOAD   = DIG_CNT_W'(NUM_DIGITS);
  localparam logic [DIG_CNT_W-1:0] DIG_ONE    = DIG_CNT_W'(1);

  logic [EFF_BITS-1:0]    bin_r,     bin_nxt;
  logic [BCD_W-1:0]       bcd_r,     bcd_nxt;
  logic [BIT_CNT_W-1:0]   bit_cnt_r, bit_cnt_nxt;
  logic [DIG_CNT_W-1:0]   dig_cnt_r, dig_cnt_nxt;
  logic                   started_r, started_nxt;
  logic                   valid_r,   valid_nxt;
  logic [CHAR_W-1:0]      char_r,    char_nxt;
  logic                   last_r,    last_nxt;
  logic [BCD_W-1:0]       bcd_adj;
  logic [BCD_DIGIT_W-1:0] top_digit;
  logic                   emit;

  // Add-3 correction on every digit that is five or more.
  always_comb begin
    logic [BCD_DIGIT_W-1:0] d;
    for (int i = 0; i < NUM_DIGITS; i++) begin
      d = bcd_r[i*BCD_DIGIT_W +: BCD_DIGIT_W];
      if (d >= 4'd5) begin
        bcd_adj[i*BCD_DIGIT_W +: BCD_DIGIT_W] = d + 4'd3;
      end else begin
        bcd_adj[i*BCD_DIGIT_W +: BCD_DIGIT_W] = d;
      end
    end
  end

  assign top_digit      = bcd_r[BCD_W-1 -: BCD_DIGIT_W];
  assign sts.shift_done = (bit_cnt_r == LAST_SHIFT);
  assign sts.scan_last  = (dig_cnt_r == DIG_ONE);
  // Leading zeros are dropped, but the units digit always goes out.
  assign emit = started_r | (top_digit != '0) | sts.scan_last;

  always_comb begin
    bin_nxt     = bin_r;
    bcd_nxt     = bcd_r;
    bit_cnt_nxt = bit_cnt_r;
    dig_cnt_nxt = dig_cnt_r;
    started_nxt = started_r;
    valid_nxt   = 1'b0;
    char_nxt    = char_r;
    last_nxt    = last_r;
    if (cmd.load) begin
      // The top bit is shifted in straight away; no digit can need a fix yet.
      bin_nxt     = {in_value[EFF_BITS-2:0], 1'b0};
      bcd_nxt     = {{(BCD_W-1){1'b0}}, in_value[EFF_BITS-1]};
      bit_cnt_nxt = '0;
      dig_cnt_nxt = DIG_LOAD;
      started_nxt = 1'b0;
    end else if (cmd.shift) begin
      bin_nxt     = {bin_r[EFF_BITS-2:0], 1'b0};
      bcd_nxt     = {bcd_adj[BCD_W-2:0], bin_r[EFF_BITS-1]};
      bit_cnt_nxt = bit_cnt_r + 1'b1;
    end else if (cmd.scan) begin
      bcd_nxt     = {bcd_r[BCD_W-BCD_DIGIT_W-1:0], {BCD_DIGIT_W{1'b0}}};
      dig_cnt_nxt = dig_cnt_r - 1'b1;
      if (emit) begin
        started_nxt = 1'b1;
        valid_nxt   = 1'b1;
        char_nxt    = ASCII_ZERO + {{(CHAR_W-BCD_DIGIT_W){1'b0}}, top_digit};
        last_nxt    = sts.scan_last;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    bin_r     <= bin_nxt;
    bcd_r     <= bcd_nxt;
    bit_cnt_r <= bit_cnt_nxt;
    dig_cnt_r <= dig_cnt_nxt;
    started_r <= started_nxt;
    char_r    <= char_nxt;
    last_r    <= last_nxt;
  end

  assign out_valid      = valid_r;
  assign out_digit_char = char_r;
  assign out_last_digit = last_r;

endmodule

/* src/binary_to_decimal_ascii_unit.sv */
// ----------------------------------------------------------------------------
// binary_to_decimal_ascii_unit
// Prints an unsigned binary value as a run of decimal ASCII digits.
// ----------------------------------------------------------------------------
// Sequence: a request is loaded, shifted through the double-dabble register,
//   then scanned out digit by digit from the top; each strobe is registered.
// Requests: a new one is taken only once the unit is idle again, after the
//   one-bit-per-cycle double-dabble shift and the one-digit-per-cycle scan.
// Reset: synchronous, active low; returns the controller to idle and drops the
//   strobe. The receiver cannot stall, so every strobe is a delivered result.
module binary_to_decimal_ascii_unit import b2da_pkg::*; #(
  parameter int VALUE_BITS = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [VALUE_W-1:0] in_value,
  output logic               out_valid,
  output logic [CHAR_W-1:0]  out_digit_char,
  output logic               out_last_digit
);

  // Only the low VALUE_BITS bits of the request field take part, and never
  // more than the field itself carries.
  localparam int EFF_BITS = (VALUE_BITS < VALUE_W) ? VALUE_BITS : VALUE_W;

  // Decimal digits of 2^EFF_BITS - 1: floor(EFF_BITS * log10(2)) + 1, with
  // log10(2) approximated as 1233 / 4096, which is exact over this range.
  localparam int NUM_DIGITS = ((EFF_BITS * 1233) >> 12) + 1;

  b2da_cmd_t cmd;
  b2da_sts_t sts;

  // The controller walks idle, convert and scan. A request is taken when
  // start is high in idle; the datapath then loads the value, with its top
  // bit already shifted into the BCD register.
  b2da_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy)
  );

  // The datapath holds the binary shifter and the packed BCD digits. During
  // the scan it pops one digit per cycle from the top, skipping leading
  // zeros, and registers each emitted character with its last-digit mark.
  b2da_datapath #(
    .EFF_BITS   (EFF_BITS),
    .NUM_DIGITS (NUM_DIGITS)
  ) u_datapath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .in_value       (in_value),
    .sts            (sts),
    .out_valid      (out_valid),
    .out_digit_char (out_digit_char),
    .out_last_digit (out_last_digit)
  );

endmodule

/* src/b2da_checker.sv */
// ----------------------------------------------------------------------------
// b2da_checker
// Port-level checks on the binary to decimal ASCII unit, bound to the top.
// ----------------------------------------------------------------------------
module b2da_checker import b2da_pkg::*; (
  input logic               clk,
  input logic               rst_n,
  input logic               start,
  input logic               busy,
  input logic [VALUE_W-1:0] in_value,
  input logic               out_valid,
  input logic [CHAR_W-1:0]  out_digit_char,
  input logic               out_last_digit
);

  // Every character is a decimal digit.
  a_char_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_digit_char >= 6'd48) && (out_digit_char <= 6'd57))
    else $error("digit character out of range");

  // A taken request makes the unit busy.
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_value == in_value)) |=> busy)
    else $error("request taken but unit not busy");

  // Strobes appear only while a request is in work or as it completes.
  a_strobe_in_work: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (busy || $fell(busy)))
    else $error("strobe outside a request");

  // Completing a request always delivers the last digit in that cycle.
  a_end_last: assert property (@(posedge clk) disable iff (!rst_n)
    ($fell(busy) && $past(rst_n)) |-> (out_valid && out_last_digit))
    else $error("request ended without a last digit");

  // Once a run has started, its digits follow on consecutive cycles until
  // the last-digit mark.
  a_more_digits: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_last_digit) |=> out_valid)
    else $error("run ended without a last-digit mark");

endmodule

bind binary_to_decimal_ascii_unit b2da_checker u_b2da_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .start          (start),
  .busy           (busy),
  .in_value       (in_value),
  .out_valid      (out_valid),
  .out_digit_char (out_digit_char),
  .out_last_digit (out_last_digit)
);
